[hw/rtl/urxf_pkg.sv]
// Shared types and constants for the UART register block with receive FIFO.
// Used by the register decoder, the FIFO and the top level.
`timescale 1ns / 1ps

package urxf_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_RX    = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_ID     = 3'd0;
  localparam logic [2:0] REG_STATUS = 3'd1;
  localparam logic [2:0] REG_CTRL   = 3'd2;
  localparam logic [2:0] REG_TXDATA = 3'd3;
  localparam logic [2:0] REG_RXDATA = 3'd4;

  localparam logic [31:0] ID_VALUE = 32'h1234_0002;

  typedef struct packed {
    logic push;
    logic pop;
  } fifo_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } fifo_sts_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_pulse;
    logic        rx_overflow;
    logic        rx_underflow;
    logic        from_fifo;
  } res_t;

endpackage

[hw/rtl/urxf_in_if.sv]
// Input channel interface: one bus access or one received byte per word.
// Depends on nothing beyond the language.
`timescale 1ns / 1ps

interface urxf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [2:0]  word_index;
  logic [31:0] write_data;
  logic [7:0]  rx_byte;

  modport source (output valid, action, word_index, write_data, rx_byte, input ready);
  modport sink   (input valid, action, word_index, write_data, rx_byte, output ready);
endinterface

[hw/rtl/urxf_out_if.sv]
// Result channel interface: read data, transmit byte and status flags per word.
// Depends on nothing beyond the language.
`timescale 1ns / 1ps

interface urxf_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        irq_pulse;
  logic        rx_overflow;
  logic        rx_underflow;

  modport source (output valid, read_data, tx_valid, tx_byte, irq_pulse, rx_overflow,
                  rx_underflow, input ready);
  modport sink   (input valid, read_data, tx_valid, tx_byte, irq_pulse, rx_overflow,
                  rx_underflow, output ready);
endinterface

[hw/rtl/uart_registers_with_rx_fifo.sv]
// Top level of the UART register block with receive FIFO.
// Depends on urxf_pkg, urxf_in_if, urxf_out_if, urxf_regs and urxf_fifo.
//
// Usage:
// The input channel carries one word per bus read, bus write or byte received
// from the serial line. The result channel returns exactly one word for every
// input word, in order: read data, transmit byte with its valid flag, an
// interrupt pulse and the overflow and underflow flags.
// An accepted word sits in an input register, is decoded and
// updates the control, status and FIFO state, and its result is registered.
// The result passes from the input register to the result register. One word
// is accepted every cycle while results are taken. The FIFO memory read port
// registers the popped byte together with the result.
// When the receiver stalls, the result register holds its word and the input
// register keeps one more; the input then deasserts ready until the result
// moves on. Synchronous reset clears the control register, the receive
// available flag, the FIFO pointers and count and both valid flags. It needs
// no clearing pass: FIFO entries are only read after they are written.
`timescale 1ns / 1ps

module uart_registers_with_rx_fifo #(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  urxf_in_if.sink     in_ch,
  urxf_out_if.source  out_ch
);

  logic                a_valid_r;
  logic [1:0]          a_action_r;
  logic [2:0]          a_index_r;
  logic [31:0]         a_wdata_r;
  logic [7:0]          a_rxbyte_r;
  logic                out_valid_r, out_valid_nxt;
  urxf_pkg::res_t      res_r;
  urxf_pkg::res_t      res;
  urxf_pkg::fifo_cmd_t cmd;
  urxf_pkg::fifo_sts_t sts;
  logic [7:0]          fifo_rd_byte;
  logic                advance;
  logic                in_take;

  assign advance      = a_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !a_valid_r || advance;
  assign in_take      = in_ch.valid && in_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      a_valid_r   <= in_take || (a_valid_r && !advance);
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_action_r <= in_ch.action;
      a_index_r  <= in_ch.word_index;
      a_wdata_r  <= in_ch.write_data;
      a_rxbyte_r <= in_ch.rx_byte;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  urxf_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (advance),
    .action     (a_action_r),
    .word_index (a_index_r),
    .write_data (a_wdata_r),
    .sts        (sts),
    .cmd        (cmd),
    .res        (res)
  );

  urxf_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_byte (a_rxbyte_r),
    .sts     (sts),
    .rd_byte (fifo_rd_byte)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.read_data    = res_r.from_fifo ? {24'd0, fifo_rd_byte} : res_r.read_data;
  assign out_ch.tx_valid     = res_r.tx_valid;
  assign out_ch.tx_byte      = res_r.tx_byte;
  assign out_ch.irq_pulse    = res_r.irq_pulse;
  assign out_ch.rx_overflow  = res_r.rx_overflow;
  assign out_ch.rx_underflow = res_r.rx_underflow;

`ifndef SYNTHESIS
  a_fifo_sts_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.empty && sts.full) && !(sts.empty && sts.last))
    else $error("FIFO status reports empty together with full or last.");

  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push && cmd.pop) && (!(cmd.push || cmd.pop) || advance))
    else $error("FIFO command issued outside an advancing item.");

  a_tx_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.tx_valid) |->
      (!res_r.from_fifo && res_r.read_data == '0 && !res_r.rx_overflow &&
       !res_r.rx_underflow))
    else $error("Transmit result carries read data or FIFO flags.");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && !advance) |=> (a_valid_r && $stable(a_action_r) && $stable(a_index_r)))
    else $error("Input register lost a word that had not moved on.");
`endif

endmodule

[hw/rtl/urxf_fifo.sv]
// Receive FIFO: byte memory with head and tail pointers, fill count and registered read.
// Depends on urxf_pkg for the command and status structs.
`timescale 1ns / 1ps

module urxf_fifo #(
  parameter int FIFO_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  urxf_pkg::fifo_cmd_t cmd,
  input  logic [7:0]         wr_byte,
  output urxf_pkg::fifo_sts_t sts,
  output logic [7:0]         rd_byte
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       rd_byte_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      head_nxt  = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
      count_nxt = count_r + CNT_ONE;
    end else if (cmd.pop) begin
      tail_nxt  = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
      count_nxt = count_r - CNT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[head_r] <= wr_byte;
    end
    if (cmd.pop) begin
      rd_byte_r <= mem[tail_r];
    end
  end

  assign sts.empty = (count_r == '0);
  assign sts.full  = (count_r == CNT_FULL);
  assign sts.last  = (count_r == CNT_ONE);
  assign rd_byte   = rd_byte_r;

endmodule

[hw/rtl/urxf_regs.sv]
// Register decoder: control and receive-available state, FIFO commands and result fields.
// Depends on urxf_pkg for codes, register indexes and structs.
`timescale 1ns / 1ps

module urxf_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic [1:0]          action,
  input  logic [2:0]          word_index,
  input  logic [31:0]         write_data,
  input  urxf_pkg::fifo_sts_t sts,
  output urxf_pkg::fifo_cmd_t cmd,
  output urxf_pkg::res_t      res
);

  logic [31:0]         ctrl_r, ctrl_nxt;
  logic                avail_r, avail_nxt;
  urxf_pkg::fifo_cmd_t cmd_raw;

  always_comb begin
    cmd_raw   = '0;
    res       = '0;
    ctrl_nxt  = ctrl_r;
    avail_nxt = avail_r;
    unique case (action)
      urxf_pkg::ACT_READ: begin
        unique case (word_index)
          urxf_pkg::REG_ID:     res.read_data = urxf_pkg::ID_VALUE;
          urxf_pkg::REG_STATUS: res.read_data = {30'd0, avail_r, 1'b1};
          urxf_pkg::REG_CTRL:   res.read_data = ctrl_r;
          urxf_pkg::REG_RXDATA: begin
            if (sts.empty) begin
              res.rx_underflow = 1'b1;
            end else begin
              cmd_raw.pop   = 1'b1;
              res.from_fifo = 1'b1;
              if (sts.last) begin
                avail_nxt     = 1'b0;
                res.irq_pulse = ctrl_r[0];
              end
            end
          end
          default: res.read_data = '0;
        endcase
      end
      urxf_pkg::ACT_WRITE: begin
        unique case (word_index)
          urxf_pkg::REG_CTRL: begin
            ctrl_nxt      = write_data;
            res.irq_pulse = write_data[0] | (avail_r & write_data[1]);
          end
          urxf_pkg::REG_TXDATA: begin
            res.tx_valid  = 1'b1;
            res.tx_byte   = write_data[7:0];
            res.irq_pulse = ctrl_r[0] | (avail_r & ctrl_r[1]);
          end
          default: ;
        endcase
      end
      urxf_pkg::ACT_RX: begin
        if (sts.full) begin
          res.rx_overflow = 1'b1;
        end else begin
          cmd_raw.push = 1'b1;
        end
        avail_nxt     = 1'b1;
        res.irq_pulse = ctrl_r[0] | ctrl_r[1];
      end
      default: ;
    endcase
  end

  assign cmd = en ? cmd_raw : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r  <= '0;
      avail_r <= 1'b0;
    end else if (en) begin
      ctrl_r  <= ctrl_nxt;
      avail_r <= avail_nxt;
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for uart_registers_with_rx_fifo: bus reads, bus writes and
// received bytes go in, and every result word is predicted and compared field by field.
// Depends on urxf_pkg, urxf_in_if, urxf_out_if and the RTL of the block.

module tb;

  localparam int FIFO_DEPTH     = 1024;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    logic [31:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq_pulse;
    logic        rx_overflow;
    logic        rx_underflow;
  } uart_result_t;

  class uart_reg_scoreboard;
    logic [31:0]  ctrl_reg;
    logic         rx_avail;
    logic [7:0]   rx_fifo [FIFO_DEPTH];
    logic [9:0]   fifo_wr_ptr;
    logic [9:0]   fifo_rd_ptr;
    logic [10:0]  fifo_level;
    uart_result_t expected_results[$];
    int words_noted;
    int words_checked;
    int mismatches;
    int overflows;
    int underflows;
    int irq_pulses;
    int tx_bytes;
    int peak_level;

    function new();
      ctrl_reg      = '0;
      rx_avail      = 1'b0;
      fifo_wr_ptr   = '0;
      fifo_rd_ptr   = '0;
      fifo_level    = '0;
      words_noted   = 0;
      words_checked = 0;
      mismatches    = 0;
      overflows     = 0;
      underflows    = 0;
      irq_pulses    = 0;
      tx_bytes      = 0;
      peak_level    = 0;
    endfunction

    function logic irq_level();
      return ctrl_reg[0] | (rx_avail & ctrl_reg[1]);
    endfunction

    function logic [9:0] next_ptr(logic [9:0] p);
      return (p == FIFO_DEPTH - 1) ? '0 : p + 10'd1;
    endfunction

    function void note_word(logic [1:0] act, logic [2:0] idx, logic [31:0] wdata,
                            logic [7:0] rbyte);
      uart_result_t r;
      r = '0;
      case (act)
        urxf_pkg::ACT_READ: begin
          case (idx)
            urxf_pkg::REG_ID:     r.read_data = urxf_pkg::ID_VALUE;
            urxf_pkg::REG_STATUS: r.read_data = {30'd0, rx_avail, 1'b1};
            urxf_pkg::REG_CTRL:   r.read_data = ctrl_reg;
            urxf_pkg::REG_RXDATA: begin
              if (fifo_level == 0) begin
                r.rx_underflow = 1'b1;
              end else begin
                r.read_data = {24'd0, rx_fifo[fifo_rd_ptr]};
                fifo_rd_ptr = next_ptr(fifo_rd_ptr);
                fifo_level  = fifo_level - 11'd1;
                if (fifo_level == 0) begin
                  rx_avail    = 1'b0;
                  r.irq_pulse = irq_level();
                end
              end
            end
            default: r.read_data = '0;
          endcase
        end
        urxf_pkg::ACT_WRITE: begin
          if (idx == urxf_pkg::REG_CTRL) begin
            ctrl_reg    = wdata;
            r.irq_pulse = irq_level();
          end else if (idx == urxf_pkg::REG_TXDATA) begin
            r.tx_valid  = 1'b1;
            r.tx_byte   = wdata[7:0];
            r.irq_pulse = irq_level();
          end
        end
        urxf_pkg::ACT_RX: begin
          if (fifo_level >= FIFO_DEPTH) begin
            r.rx_overflow = 1'b1;
          end else begin
            rx_fifo[fifo_wr_ptr] = rbyte;
            fifo_wr_ptr = next_ptr(fifo_wr_ptr);
            fifo_level  = fifo_level + 11'd1;
            if (int'(fifo_level) > peak_level) peak_level = int'(fifo_level);
          end
          rx_avail    = 1'b1;
          r.irq_pulse = irq_level();
        end
        default: r = '0;
      endcase
      overflows  += int'(r.rx_overflow);
      underflows += int'(r.rx_underflow);
      irq_pulses += int'(r.irq_pulse);
      tx_bytes   += int'(r.tx_valid);
      words_noted++;
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
        $display("MISMATCH at result %0d, %s: got %h, expected %h",
                 words_checked, what, got, want);
    endtask

    task check_word(uart_result_t got);
      uart_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending", got.read_data, '0);
        return;
      end
      want = expected_results.pop_front();
      if (got.read_data !== want.read_data)
        report_mismatch("read_data", got.read_data, want.read_data);
      if (got.tx_valid !== want.tx_valid)
        report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      if (got.irq_pulse !== want.irq_pulse)
        report_mismatch("irq_pulse", 32'(got.irq_pulse), 32'(want.irq_pulse));
      if (got.rx_overflow !== want.rx_overflow)
        report_mismatch("rx_overflow", 32'(got.rx_overflow), 32'(want.rx_overflow));
      if (got.rx_underflow !== want.rx_underflow)
        report_mismatch("rx_underflow", 32'(got.rx_underflow), 32'(want.rx_underflow));
      words_checked++;
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  urxf_in_if  in_ch ();
  urxf_out_if out_ch ();

  uart_registers_with_rx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  uart_reg_scoreboard sb;
  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  bit pressure_armed = 1'b0;
  bit pressure_done  = 1'b0;
  int hold_left      = 0;
  int idle_cycles    = 0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (pressure_armed && !pressure_done) begin
      out_ch.ready  <= 1'b0;
      pressure_done <= 1'b1;
      hold_left     <= HOLD_CYCLES;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.action, in_ch.word_index, in_ch.write_data, in_ch.rx_byte);
      if (out_ch.valid && out_ch.ready)
        sb.check_word({out_ch.read_data, out_ch.tx_valid, out_ch.tx_byte, out_ch.irq_pulse,
                       out_ch.rx_overflow, out_ch.rx_underflow});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                 idle_cycles, sb.expected_results.size());
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_word(input logic [1:0] act, input logic [2:0] idx,
                           input logic [31:0] wdata, input logic [7:0] rbyte);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.action     <= act;
    in_ch.word_index <= idx;
    in_ch.write_data <= wdata;
    in_ch.rx_byte    <= rbyte;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random_word();
    int pick;
    logic [1:0] act;
    logic [2:0] idx;
    pick = $urandom_range(99);
    if (pick < 40)      act = urxf_pkg::ACT_READ;
    else if (pick < 74) act = urxf_pkg::ACT_WRITE;
    else if (pick < 96) act = urxf_pkg::ACT_RX;
    else                act = urxf_pkg::ACT_NONE;
    if ($urandom_range(9) == 0) begin
      idx = 3'($urandom_range(7, 5));
    end else if (act == urxf_pkg::ACT_READ && $urandom_range(1) == 1) begin
      idx = urxf_pkg::REG_RXDATA;
    end else begin
      idx = 3'($urandom_range(4));
    end
    send_word(act, idx, $urandom, 8'($urandom));
  endtask

  task automatic send_random_words(input int count);
    repeat (count) send_random_word();
  endtask

  initial begin
    sb = new();
    in_ch.valid      = 1'b0;
    in_ch.action     = urxf_pkg::ACT_NONE;
    in_ch.word_index = '0;
    in_ch.write_data = '0;
    in_ch.rx_byte    = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 11;
    recv_idle_pct = 59;

    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_ID,     '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_STATUS, '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_CTRL,   '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_TXDATA, '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_RXDATA, '0,            '0);
    send_word(urxf_pkg::ACT_READ,  3'd5,                 '0,            '0);
    send_word(urxf_pkg::ACT_READ,  3'd7,                 '1,            '1);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_ID,     '1,            '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_STATUS, '1,            '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_RXDATA, '1,            '0);
    send_word(urxf_pkg::ACT_WRITE, 3'd6,                 '1,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_ID,     '0,            '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_CTRL,   32'h1,         '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_TXDATA, '1,            '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_CTRL,   32'h2,         '0);
    send_word(urxf_pkg::ACT_RX,    urxf_pkg::REG_ID,     '0,            8'h00);
    send_word(urxf_pkg::ACT_RX,    urxf_pkg::REG_ID,     '0,            8'hFF);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_STATUS, '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_RXDATA, '0,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_RXDATA, '0,            '0);
    send_word(urxf_pkg::ACT_NONE,  3'd7,                 '1,            '1);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_CTRL,   '1,            '0);
    send_word(urxf_pkg::ACT_READ,  urxf_pkg::REG_CTRL,   '0,            '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_TXDATA, 32'hFFFF_FF00, '0);
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_CTRL,   '0,            '0);

    // The receiver holds off while words keep coming, so the block backs up.
    pressure_armed = 1'b1;
    send_random_words(30);

    send_random_words(300);

    send_idle_pct = 59;
    recv_idle_pct = 11;
    send_random_words(300);

    // Fill the receive FIFO deeply, then drain it past empty.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(urxf_pkg::ACT_WRITE, urxf_pkg::REG_CTRL, 32'h2, '0);
    repeat (200) send_word(urxf_pkg::ACT_RX, 3'($urandom), $urandom, 8'($urandom));
    send_word(urxf_pkg::ACT_READ, urxf_pkg::REG_STATUS, '0, '0);
    repeat (240) send_word(urxf_pkg::ACT_READ, urxf_pkg::REG_RXDATA, $urandom, 8'($urandom));

    send_random_words(100);

    in_ch.valid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d words through the block: %0d transmit bytes, %0d interrupt pulses.",
             sb.words_noted, sb.tx_bytes, sb.irq_pulses);
    $display("FIFO peaked at %0d of %0d, %0d overflows, %0d underflows, %0d mismatches.",
             sb.peak_level, FIFO_DEPTH, sb.overflows, sb.underflows, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/urxf_pkg.sv
hw/rtl/urxf_in_if.sv
hw/rtl/urxf_out_if.sv
hw/rtl/urxf_fifo.sv
hw/rtl/urxf_regs.sv
hw/rtl/uart_registers_with_rx_fifo.sv
tb/tb.sv
